FILE: hdl/jse_pkg.sv
// Shared types, constants and helper functions for the JSON string escaper.
package jse_pkg;

   typedef enum logic [1:0] {
      ESC_NONE    = 2'd0,
      ESC_SHORT   = 2'd1,
      ESC_UNICODE = 2'd2
   } esc_kind_type;

   typedef struct packed {
      logic [7:0]   char_code;
      logic         string_end;
      esc_kind_type kind;
   } esc_item_type;

   localparam int unsigned STEP_W = 3;

   localparam logic [STEP_W-1:0] LEN_NONE    = 3'd1;
   localparam logic [STEP_W-1:0] LEN_SHORT   = 3'd2;
   localparam logic [STEP_W-1:0] LEN_UNICODE = 3'd6;

   // Positions inside a unicode escape sequence
   localparam logic [STEP_W-1:0] POS_LEAD   = 3'd0;
   localparam logic [STEP_W-1:0] POS_TAG    = 3'd1;
   localparam logic [STEP_W-1:0] POS_ZERO_A = 3'd2;
   localparam logic [STEP_W-1:0] POS_ZERO_B = 3'd3;
   localparam logic [STEP_W-1:0] POS_HEX_HI = 3'd4;
   localparam logic [STEP_W-1:0] POS_HEX_LO = 3'd5;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0a;
   localparam logic [7:0] CH_RETURN    = 8'h0d;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PRINT_TOP = 8'h7f;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_N   = 8'h6e;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   function automatic esc_kind_type classify(input logic [7:0] c);
      esc_kind_type k;
      if (c == CH_BACKSPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN ||
          c == CH_QUOTE || c == CH_BACKSLASH) begin
         k = ESC_SHORT;
      end else if (c < CH_SPACE || c > CH_PRINT_TOP) begin
         k = ESC_UNICODE;
      end else begin
         k = ESC_NONE;
      end
      return k;
   endfunction

   // Byte that follows the backslash in a two-byte escape
   function automatic logic [7:0] short_letter(input logic [7:0] c);
      logic [7:0] l;
      case (c)
         CH_BACKSPACE: l = CH_LOWER_B;
         CH_TAB:       l = CH_LOWER_T;
         CH_NEWLINE:   l = CH_LOWER_N;
         CH_RETURN:    l = CH_LOWER_R;
         default:      l = c;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) begin
         d = CH_ZERO + {4'b0, n};
      end else begin
         d = CH_LOWER_A + {4'b0, n - 4'd10};
      end
      return d;
   endfunction

   function automatic logic [STEP_W-1:0] run_length(input esc_kind_type k);
      logic [STEP_W-1:0] n;
      case (k)
         ESC_NONE:    n = LEN_NONE;
         ESC_SHORT:   n = LEN_SHORT;
         ESC_UNICODE: n = LEN_UNICODE;
         default:     n = LEN_NONE;
      endcase
      return n;
   endfunction

endpackage

FILE: hdl/jse_if.sv
// Valid/ready channel interfaces for the escaper's input and output items.
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       string_end;

   modport source (output valid, char_code, string_end, input ready);
   modport sink (input valid, char_code, string_end, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;

   modport source (output valid, out_byte, run_last, string_done, input ready);
   modport sink (input valid, out_byte, run_last, string_done, output ready);
endinterface

FILE: hdl/jse_front.sv
// Front end: accepts input bytes, classifies them and pushes them into the queue.
module jse_front
   import jse_pkg::*;
(
   jse_req_if.sink      req,
   input  logic         full,
   output logic         push,
   output esc_item_type push_item
);

   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      push_item.char_code  = req.char_code;
      push_item.string_end = req.string_end;
      push_item.kind       = classify(req.char_code);
   end

endmodule

FILE: hdl/jse_queue.sv
// Short register queue that decouples the classifier from the byte sequencer.
module jse_queue
   import jse_pkg::*;
#(
   parameter int unsigned Depth = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  esc_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output esc_item_type head_item
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   esc_item_type         slot_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full      = count_ff == CntW'(Depth);
   assign not_empty = count_ff != '0;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/jse_back.sv
// Back end: steps through each queued byte's escape sequence into an output register.
module jse_back
   import jse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         not_empty,
   input  esc_item_type head_item,
   output logic         pop,
   jse_rsp_if.source    rsp
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              run_last_ff, run_last_in;
   logic              string_done_ff, string_done_in;

   logic              load;
   logic              at_last;
   logic [7:0]        cur_byte;

   assign load    = not_empty && (!out_valid_ff || rsp.ready);
   assign at_last = step_ff == run_length(head_item.kind) - 1'b1;
   assign pop     = load && at_last;

   always_comb begin
      cur_byte = CH_BACKSLASH;
      if (head_item.kind == ESC_NONE) begin
         cur_byte = head_item.char_code;
      end else begin
         case (step_ff)
            POS_LEAD:   cur_byte = CH_BACKSLASH;
            POS_TAG:    cur_byte = (head_item.kind == ESC_SHORT) ?
                                   short_letter(head_item.char_code) : CH_LOWER_U;
            POS_ZERO_A: cur_byte = CH_ZERO;
            POS_ZERO_B: cur_byte = CH_ZERO;
            POS_HEX_HI: cur_byte = hex_digit(head_item.char_code[7:4]);
            POS_HEX_LO: cur_byte = hex_digit(head_item.char_code[3:0]);
            default:    cur_byte = CH_BACKSLASH;
         endcase
      end
   end

   always_comb begin
      step_in        = step_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_byte_in    = out_byte_ff;
      run_last_in    = run_last_ff;
      string_done_in = string_done_ff;
      if (load) begin
         // advance within the run, restart on its last byte
         step_in        = at_last ? '0 : step_ff + 1'b1;
         out_valid_in   = 1'b1;
         out_byte_in    = cur_byte;
         run_last_in    = at_last;
         string_done_in = at_last && head_item.string_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff    <= out_byte_in;
      run_last_ff    <= run_last_in;
      string_done_ff <= string_done_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.run_last    = run_last_ff;
   assign rsp.string_done = string_done_ff;

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < LEN_UNICODE)
      else $error("sequence step out of range");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!string_done_ff || run_last_ff))
      else $error("string end flagged on a byte that does not close its run");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff && run_last_ff)
      else $error("queue popped without closing the run");
`endif

endmodule

FILE: hdl/json_string_escaper_top.sv
// JSON string escaper: input byte channel, classifier, queue, sequencer, output byte channel.
//
// req carries one string byte per item (char_code) and a flag on the string's last
// byte (string_end). rsp carries the escaped form, one byte per item: the byte
// itself, a two-byte backslash escape, or a six-byte \u00XX escape with lower-case
// hex. run_last marks the final output byte of each input, and string_done is set
// on that byte when the input carried string_end.
// An input's first output byte passes through a queue slot, then the output register.
// Throughput, while the receiver is ready: one output byte per cycle, set by the single
// output register of the sequencer. An input that expands into N bytes occupies the
// sequencer until its last byte is loaded; plain bytes flow at one input per cycle. The
// queue of QueueDepth entries lets input keep arriving while an escape is emitted.
// Reset is synchronous and empties the queue and the output register; no clearing
// pass follows, input is taken in the first cycle after reset.
// When the receiver stalls, the output item holds and the queue fills; req.ready
// drops once the queue is full.
module json_string_escaper_top
   import jse_pkg::*;
#(
   parameter int unsigned QueueDepth = 4
) (
   input logic       clock,
   input logic       reset,
   jse_req_if.sink   req,
   jse_rsp_if.source rsp
);

   logic         full;
   logic         push;
   logic         pop;
   logic         not_empty;
   esc_item_type push_item;
   esc_item_type head_item;

   jse_front u_front (
      .req       (req),
      .full      (full),
      .push      (push),
      .push_item (push_item)
   );

   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

FILE: dv/json_string_escaper_top_tb.sv
// Testbench for the JSON string escaper: directed and random valid/ready traffic checked by a scoreboard.
`timescale 1ns / 1ps

module json_string_escaper_top_tb
   import jse_pkg::*;
;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_CHARS = 128;
   localparam int LONG_HOLD    = 60;
   localparam int SETTLE       = 10;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } escaped_byte_type;

   // Expands each accepted string byte into the bytes the escaper should emit.
   class escape_scoreboard;
      escaped_byte_type escaped_q[$];
      int mismatches = 0;

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function int outstanding();
         return escaped_q.size();
      endfunction

      function void note_char(input logic [7:0] c, input logic string_end);
         string hex_chars = "0123456789abcdef";
         logic [7:0] seq[6];
         int n;
         escaped_byte_type exp_byte;
         seq[0] = CH_BACKSLASH;
         n = 2;
         case (c)
            CH_BACKSPACE: seq[1] = CH_LOWER_B;
            CH_TAB:       seq[1] = CH_LOWER_T;
            CH_NEWLINE:   seq[1] = CH_LOWER_N;
            CH_RETURN:    seq[1] = CH_LOWER_R;
            CH_QUOTE, CH_BACKSLASH: seq[1] = c;
            default: begin
               if (c < CH_SPACE || c > CH_PRINT_TOP) begin
                  seq[1] = CH_LOWER_U;
                  seq[2] = CH_ZERO;
                  seq[3] = CH_ZERO;
                  seq[4] = hex_chars[c[7:4]];
                  seq[5] = hex_chars[c[3:0]];
                  n = 6;
               end else begin
                  seq[0] = c;
                  n = 1;
               end
            end
         endcase
         for (int k = 0; k < n; k++) begin
            exp_byte.out_byte    = seq[k];
            exp_byte.run_last    = (k == n - 1);
            exp_byte.string_done = (k == n - 1) && string_end;
            escaped_q.push_back(exp_byte);
         end
      endfunction

      task check_result(input logic [7:0] b, input logic last, input logic done);
         escaped_byte_type exp_byte;
         if (escaped_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item out_byte=%h", b));
         end else begin
            exp_byte = escaped_q.pop_front();
            if (b !== exp_byte.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h", b, exp_byte.out_byte));
            if (last !== exp_byte.run_last)
               report_mismatch($sformatf("run_last %b, want %b (out_byte %h)",
                                         last, exp_byte.run_last, exp_byte.out_byte));
            if (done !== exp_byte.string_done)
               report_mismatch($sformatf("string_done %b, want %b (out_byte %h)",
                                         done, exp_byte.string_done, exp_byte.out_byte));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic no_idle;
   logic long_hold;
   int   cycles = 0;

   jse_req_if req_ch ();
   jse_rsp_if rsp_ch ();

   escape_scoreboard sb = new();

   json_string_escaper_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [7:0] directed_chars [22] = '{
      8'h01, 8'hff, CH_BACKSPACE, CH_NEWLINE, CH_RETURN, CH_TAB, CH_QUOTE, CH_BACKSLASH,
      8'h1f, CH_SPACE, 8'h7e, CH_PRINT_TOP, 8'h80, 8'h41, 8'h00, 8'hab,
      8'hcd, 8'hef, 8'h9a, 8'h5b, 8'h0b, 8'h55
   };

   logic [7:0] short_escapes [6] = '{
      CH_BACKSPACE, CH_TAB, CH_NEWLINE, CH_RETURN, CH_QUOTE, CH_BACKSLASH
   };

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int next_gap();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   // Mix of plain, short-escape, control and high bytes
   function automatic logic [7:0] pick_char();
      int sel;
      logic [7:0] c;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         c = 8'($urandom_range(CH_SPACE, CH_PRINT_TOP));
      else if (sel < 6)
         c = short_escapes[$urandom_range(0, 5)];
      else if (sel < 8)
         c = 8'($urandom_range(0, 8'h1f));
      else
         c = 8'($urandom_range(8'h80, 8'hff));
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic string_end, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_code  <= c;
      req_ch.string_end <= string_end;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_char(c, string_end);
   endtask

   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      logic held;
      rsp_ch.ready = 1'b0;
      held         = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold && !held) begin
            stall = LONG_HOLD;
            held  = 1'b1;
         end else begin
            stall = next_gap();
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         sb.check_result(rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.string_done);
      end
   end

   initial begin
      int sent;
      int len;
      int strings;
      logic broken;
      clock             = 1'b0;
      reset             = 1'b1;
      no_idle           = 1'b0;
      long_hold         = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.char_code  = 8'h00;
      req_ch.string_end = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_chars[i])
         send_char(directed_chars[i], (i % 3) == 2, next_gap());
      @(negedge clock);
      req_ch.valid <= 1'b0;
      drain();

      sent    = 0;
      strings = 0;
      while (sent < RANDOM_CHARS) begin
         len     = $urandom_range(1, 12);
         no_idle = ($urandom_range(0, 3) == 0);
         broken  = ($urandom_range(0, 7) == 0);
         if (strings == 4) begin
            // stall the output while bytes keep coming so the queue fills
            len       = 12;
            no_idle   = 1'b1;
            long_hold = 1'b1;
         end
         if (strings == 8) begin
            // hold input until the block has emptied
            @(negedge clock);
            req_ch.valid <= 1'b0;
            drain();
         end
         for (int k = 0; k < len; k++)
            send_char(pick_char(), broken ? 1'($urandom_range(0, 1)) : (k == len - 1),
                      next_gap());
         sent += len;
         strings++;
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report_mismatch($sformatf("%0d items never arrived", sb.outstanding()));
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
hdl/jse_pkg.sv
hdl/jse_if.sv
hdl/jse_front.sv
hdl/jse_queue.sv
hdl/jse_back.sv
hdl/json_string_escaper_top.sv
dv/json_string_escaper_top_tb.sv
